FILE: design/spd_pkg.sv
// Package for the spectral peak detector: widths, register codes, reset
// values and the beat structs passed between the pipeline stages.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package spd_pkg;

  localparam int COMP_W   = 16;                   // bin component width
  localparam int MAX_BINS = 128;                  // bins taken per spectrum
  localparam int IDX_W    = $clog2(MAX_BINS);     // bin index width
  localparam int CNT_W    = $clog2(MAX_BINS + 1); // bin counter, holds MAX_BINS
  localparam int POW_W    = 2 * COMP_W;           // re^2 + im^2 fits here
  localparam int TOT_W    = POW_W + IDX_W;        // sum of MAX_BINS powers

  localparam int RATIO_W  = 10;
  localparam int COUNT_W  = 12;
  localparam int LHS_W    = POW_W + COUNT_W;
  localparam int RHS_W    = TOT_W + RATIO_W;

  localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(100);
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(250);

  // APB
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic REG_RATIO = 1'b0;
  localparam logic REG_COUNT = 1'b1;

  typedef struct packed {
    logic             last;
    logic [POW_W-1:0] power;
  } power_beat_t;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic [POW_W-1:0] best;
    logic [TOT_W-1:0] total;
  } spectrum_sum_t;

endpackage
`default_nettype wire

FILE: design/spd_regs.sv
// APB register block: ratio_threshold and sample_count.
// Depends on spd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module spd_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [spd_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [spd_pkg::DATA_W-1:0]  pwdata,
  output logic      [spd_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  output logic      [spd_pkg::RATIO_W-1:0] ratio_threshold,
  output logic      [spd_pkg::COUNT_W-1:0] sample_count
);
  import spd_pkg::*;

  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      ratio_threshold <= RATIO_RESET;
      sample_count    <= COUNT_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_RATIO: ratio_threshold <= pwdata[RATIO_W-1:0];
        REG_COUNT: sample_count    <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_RATIO: prdata = DATA_W'(ratio_threshold);
      REG_COUNT: prdata = DATA_W'(sample_count);
      default:   prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: design/spd_power.sv
// Input register and bin power stage: re*re + im*im per beat.
// Depends on spd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module spd_power (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic signed [spd_pkg::COMP_W-1:0] bin_real,
  input  wire logic signed [spd_pkg::COMP_W-1:0] bin_imag,
  input  wire logic                       last_bin,
  output logic                            pw_valid,
  output spd_pkg::power_beat_t            pw_beat,
  input  wire logic                       pw_ready
);
  import spd_pkg::*;

  logic                     a_valid;
  logic signed [COMP_W-1:0] a_re;
  logic signed [COMP_W-1:0] a_im;
  logic                     a_last;
  logic                     a_adv;
  logic                     b_adv;
  logic signed [POW_W-1:0]  sq_re;
  logic signed [POW_W-1:0]  sq_im;

  assign b_adv    = !pw_valid || pw_ready;
  assign a_adv    = !a_valid || b_adv;
  assign in_stall = !a_adv;

  // each square is at most 2^(2*COMP_W-2), so the sum fits unsigned POW_W
  assign sq_re = POW_W'(a_re) * POW_W'(a_re);
  assign sq_im = POW_W'(a_im) * POW_W'(a_im);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid  <= 1'b0;
      pw_valid <= 1'b0;
    end else begin
      if (a_adv) a_valid <= in_valid;
      if (b_adv) pw_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv && in_valid) begin
      a_re   <= bin_real;
      a_im   <= bin_imag;
      a_last <= last_bin;
    end
    if (b_adv && a_valid) begin
      pw_beat.power <= $unsigned(sq_re) + $unsigned(sq_im);
      pw_beat.last  <= a_last;
    end
  end

endmodule
`default_nettype wire

FILE: design/spd_accum.sv
// Running max, first index of max and power sum over one spectrum; on the
// last bin the totals are latched for the decision stage and state clears.
// Depends on spd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module spd_accum (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   pw_valid,
  input  wire spd_pkg::power_beat_t   pw_beat,
  output logic                        pw_ready,
  output logic                        res_valid,
  output spd_pkg::spectrum_sum_t      res,
  input  wire logic                   res_ready
);
  import spd_pkg::*;

  logic [POW_W-1:0] best_power;
  logic [IDX_W-1:0] best_index;
  logic [CNT_W-1:0] bin_position;
  logic [TOT_W-1:0] power_total;

  logic [POW_W-1:0] best_power_next;
  logic [IDX_W-1:0] best_index_next;
  logic [CNT_W-1:0] bin_position_next;
  logic [TOT_W-1:0] power_total_next;

  logic res_adv;
  logic fire;
  logic full;

  assign res_adv  = !res_valid || res_ready;
  // a last beat must wait for the result slot; others always go
  assign pw_ready = !pw_beat.last || res_adv;
  assign fire     = pw_valid && pw_ready;
  assign full     = (bin_position == CNT_W'(MAX_BINS));

  always_comb begin
    best_power_next   = best_power;
    best_index_next   = best_index;
    bin_position_next = bin_position;
    power_total_next  = power_total;
    if (!full) begin
      if (pw_beat.power > best_power) begin  // strict: earlier bin wins ties
        best_power_next = pw_beat.power;
        best_index_next = bin_position[IDX_W-1:0];
      end
      power_total_next  = power_total + TOT_W'(pw_beat.power);
      bin_position_next = bin_position + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_power   <= '0;
      best_index   <= '0;
      bin_position <= '0;
      power_total  <= '0;
      res_valid    <= 1'b0;
    end else begin
      if (res_adv) res_valid <= fire && pw_beat.last;
      if (fire) begin
        if (pw_beat.last) begin
          best_power   <= '0;
          best_index   <= '0;
          bin_position <= '0;
          power_total  <= '0;
        end else begin
          best_power   <= best_power_next;
          best_index   <= best_index_next;
          bin_position <= bin_position_next;
          power_total  <= power_total_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && pw_beat.last) begin
      res.index <= best_index_next;
      res.best  <= best_power_next;
      res.total <= power_total_next;
    end
  end

endmodule
`default_nettype wire

FILE: design/spd_decide.sv
// Significance test best*sample_count > total*ratio: product stage, then
// the compare into the output register.
// Depends on spd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module spd_decide (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        res_valid,
  input  wire spd_pkg::spectrum_sum_t      res,
  output logic                             res_ready,
  input  wire logic [spd_pkg::RATIO_W-1:0] ratio_threshold,
  input  wire logic [spd_pkg::COUNT_W-1:0] sample_count,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [spd_pkg::IDX_W-1:0]   peak_index,
  output logic      [spd_pkg::POW_W-1:0]   peak_power,
  output logic                             significant
);
  import spd_pkg::*;

  logic             d_valid;
  logic [IDX_W-1:0] d_index;
  logic [POW_W-1:0] d_power;
  logic [LHS_W-1:0] d_lhs;
  logic [RHS_W-1:0] d_rhs;
  logic             d_adv;
  logic             e_adv;

  assign e_adv     = !out_valid || !out_stall;
  assign d_adv     = !d_valid || e_adv;
  assign res_ready = d_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (d_adv) d_valid <= res_valid;
      if (e_adv) out_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (d_adv && res_valid) begin
      d_index <= res.index;
      d_power <= res.best;
      d_lhs   <= LHS_W'(res.best) * LHS_W'(sample_count);
      d_rhs   <= RHS_W'(res.total) * RHS_W'(ratio_threshold);
    end
    if (e_adv && d_valid) begin
      peak_index  <= d_index;
      peak_power  <= d_power;
      significant <= (RHS_W'(d_lhs) > d_rhs);
    end
  end

endmodule
`default_nettype wire

FILE: design/spectral_peak_detector_top.sv
// Spectral peak detector top level: power stage, accumulator, decision
// stage and APB registers. Depends on spd_pkg and all spd_* modules.
//
// Takes one complex bin per cycle while in_stall is low (bin_real,
// bin_imag signed) and forms its power re^2 + im^2. Over one spectrum it
// tracks the largest power, the first bin index holding it, and the sum
// of all powers; bins past the 128th add nothing. The beat with last_bin
// set closes the spectrum: one result beat carries peak_index, peak_power
// and significant, set when peak_power * sample_count > power_sum *
// ratio_threshold, and the accumulator clears. A new bin is taken every
// cycle while in_stall is low, including the bin right after a last one.
// From the input register a result moves through the power, accumulator,
// product and compare registers. Input stall rises only when results
// back up through the pipeline behind a stalled output. Registers:
// ratio_threshold at byte address 0 (reset 100), sample_count at 4
// (reset 250); write them only while no spectrum is in flight.
`timescale 1ns / 1ps
`default_nettype none
module spectral_peak_detector_top (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [spd_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [spd_pkg::DATA_W-1:0]  pwdata,
  output logic      [spd_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic signed [spd_pkg::COMP_W-1:0] bin_real,
  input  wire logic signed [spd_pkg::COMP_W-1:0] bin_imag,
  input  wire logic                        last_bin,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [spd_pkg::IDX_W-1:0]   peak_index,
  output logic      [spd_pkg::POW_W-1:0]   peak_power,
  output logic                             significant
);
  import spd_pkg::*;

  logic [RATIO_W-1:0] ratio_threshold;
  logic [COUNT_W-1:0] sample_count;
  logic               pw_valid;
  power_beat_t        pw_beat;
  logic               pw_ready;
  logic               res_valid;
  spectrum_sum_t      res;
  logic               res_ready;

  spd_regs u_regs (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .ratio_threshold (ratio_threshold),
    .sample_count    (sample_count)
  );

  spd_power u_power (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .bin_real (bin_real),
    .bin_imag (bin_imag),
    .last_bin (last_bin),
    .pw_valid (pw_valid),
    .pw_beat  (pw_beat),
    .pw_ready (pw_ready)
  );

  spd_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .pw_valid  (pw_valid),
    .pw_beat   (pw_beat),
    .pw_ready  (pw_ready),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  spd_decide u_decide (
    .clk             (clk),
    .rst             (rst),
    .res_valid       (res_valid),
    .res             (res),
    .res_ready       (res_ready),
    .ratio_threshold (ratio_threshold),
    .sample_count    (sample_count),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .peak_index      (peak_index),
    .peak_power      (peak_power),
    .significant     (significant)
  );

endmodule
`default_nettype wire
